[rtl/apt_pkg.sv]
// shared types and constants for the affine point transform
// no dependencies; imported by every module of the block

package apt_pkg;

  localparam int WordW      = 32;
  localparam int FracBitsDef = 16;
  localparam int CoefNum    = 12;
  localparam int CoefIdxW   = 4;
  localparam int RowNum     = 3;
  localparam int ColNum     = 4;
  localparam int ProdW      = 2 * WordW;
  // products plus scaled translation, with headroom for four terms
  localparam int AccW       = ProdW + 2;

  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActPoint = 2'd1,
    ActDir   = 2'd2
  } action_e;

  typedef logic signed [WordW-1:0] word_t;
  typedef word_t [CoefNum-1:0] coef_mat_t;
  typedef word_t [RowNum-1:0] vec_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef acc_t [RowNum-1:0] acc_vec_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [CoefIdxW-1:0]   coef_index;
    logic signed [WordW-1:0] coef_value;
    logic signed [WordW-1:0] in_x;
    logic signed [WordW-1:0] in_y;
    logic signed [WordW-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] out_x;
    logic signed [WordW-1:0] out_y;
    logic signed [WordW-1:0] out_z;
    logic                    overflow;
  } out_item_t;

  typedef struct packed {
    logic                  en;
    logic [CoefIdxW-1:0]   idx;
    logic signed [WordW-1:0] value;
  } coef_wr_t;

  typedef struct packed {
    acc_vec_t s01;
    acc_vec_t s2t;
  } part_sum_t;

endpackage

[rtl/apt_coef_store.sv]
// twelve coefficient registers, reset to the identity rows
// depends on apt_pkg

module apt_coef_store #(
  parameter int FRAC_BITS = apt_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apt_pkg::coef_wr_t  wr_i,
  output apt_pkg::coef_mat_t coef_o
);
  import apt_pkg::*;

  localparam word_t Ident = word_t'({{(WordW-1){1'b0}}, 1'b1} << FRAC_BITS);
  localparam int Diag0 = 0;
  localparam int Diag1 = ColNum + 1;
  localparam int Diag2 = 2 * (ColNum + 1);

  coef_mat_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CoefNum; i++) begin
        coef_q[i] <= '0;
      end
      coef_q[Diag0] <= Ident;
      coef_q[Diag1] <= Ident;
      coef_q[Diag2] <= Ident;
    end else if (wr_i.en && (wr_i.idx < CoefIdxW'(CoefNum))) begin
      coef_q[wr_i.idx] <= wr_i.value;
    end
  end

  assign coef_o = coef_q;

endmodule

[rtl/apt_mul.sv]
// multiply stage and first adder stage of the transform pipeline
// depends on apt_pkg; coefficients sampled as an item enters

module apt_mul #(
  parameter int FRAC_BITS = apt_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               point_i,
  input  apt_pkg::vec_t      vec_i,
  input  apt_pkg::coef_mat_t coef_i,
  output logic               valid_o,
  input  logic               ready_i,
  output apt_pkg::part_sum_t psum_o
);
  import apt_pkg::*;

  typedef logic signed [ProdW-1:0] prod_t;

  logic  v1_q, v2_q;
  logic  en1, en2;
  prod_t prod_q [RowNum][RowNum];
  word_t trans_q [RowNum];
  logic  point_q;
  part_sum_t psum_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      point_q <= point_i;
      for (int r = 0; r < RowNum; r++) begin
        trans_q[r] <= coef_i[r*ColNum + RowNum];
        for (int c = 0; c < RowNum; c++) begin
          prod_q[r][c] <= ProdW'(coef_i[r*ColNum + c]) * ProdW'(vec_i[c]);
        end
      end
    end
  end

  acc_vec_t s01_d, s2t_d;

  always_comb begin
    acc_t tr;
    for (int r = 0; r < RowNum; r++) begin
      tr = {{(AccW-WordW){trans_q[r][WordW-1]}}, trans_q[r]} <<< FRAC_BITS;
      s01_d[r] = {{(AccW-ProdW){prod_q[r][0][ProdW-1]}}, prod_q[r][0]}
               + {{(AccW-ProdW){prod_q[r][1][ProdW-1]}}, prod_q[r][1]};
      s2t_d[r] = {{(AccW-ProdW){prod_q[r][2][ProdW-1]}}, prod_q[r][2]}
               + (point_q ? tr : acc_t'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      psum_q.s01 <= s01_d;
      psum_q.s2t <= s2t_d;
    end
  end

  assign valid_o = v2_q;
  assign psum_o  = psum_q;

endmodule

[rtl/apt_sum_sat.sv]
// final adder stage, then shift, saturation and the output register
// depends on apt_pkg

module apt_sum_sat #(
  parameter int FRAC_BITS = apt_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  apt_pkg::part_sum_t psum_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output apt_pkg::out_item_t out_item_o
);
  import apt_pkg::*;

  logic      v3_q, ov_q;
  logic      en3, eno;
  acc_vec_t  acc_q;
  out_item_t out_q;

  assign eno     = !ov_q || !out_stall_i;
  assign en3     = !v3_q || eno;
  assign ready_o = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (eno) ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) begin
      for (int r = 0; r < RowNum; r++) begin
        acc_q[r] <= psum_i.s01[r] + psum_i.s2t[r];
      end
    end
  end

  vec_t res;
  logic [RowNum-1:0] sat;

  always_comb begin
    acc_t sh;
    logic [AccW-WordW:0] upper;
    for (int r = 0; r < RowNum; r++) begin
      sh     = acc_q[r] >>> FRAC_BITS;
      upper  = sh[AccW-1:WordW-1];
      sat[r] = !((&upper) || !(|upper));
      if (sat[r]) begin
        res[r] = sh[AccW-1] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
      end else begin
        res[r] = sh[WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno && v3_q) begin
      out_q.out_x    <= res[0];
      out_q.out_y    <= res[1];
      out_q.out_z    <= res[2];
      out_q.overflow <= |sat;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

endmodule

[rtl/affine_point_transform.sv]
// Affine point transform. Holds the upper three rows of a 4x4 matrix as twelve
// signed Q16.16 coefficients (identity after reset) and returns M*(x,y,z,1) for a
// point item or the 3x3 part times (x,y,z) for a direction item, each component
// floored by the fraction shift and saturated, with an overflow flag. One item is
// taken every clock while in_stall_o is low. An accepted item passes through the
// register stages multiply, pair add, final add, and shift/saturate. A write item
// updates its coefficient at once, gives no result, and applies to every
// item accepted after it. Stalls propagate back stage by stage, so bubbles close.
// depends on apt_pkg, apt_coef_store, apt_mul, apt_sum_sat

module affine_point_transform #(
  parameter int FRAC_BITS = apt_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  apt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output apt_pkg::out_item_t out_item_o
);
  import apt_pkg::*;

  logic      accept, is_xf, mul_ready, mid_valid, mid_ready;
  coef_wr_t  wr;
  coef_mat_t coef;
  vec_t      vec;
  part_sum_t psum;

  assign in_stall_o = !mul_ready;
  assign accept     = in_valid_i && mul_ready;
  assign is_xf      = (in_item_i.action == ActPoint) || (in_item_i.action == ActDir);

  assign wr.en    = accept && (in_item_i.action == ActWrite);
  assign wr.idx   = in_item_i.coef_index;
  assign wr.value = in_item_i.coef_value;

  assign vec[0] = in_item_i.in_x;
  assign vec[1] = in_item_i.in_y;
  assign vec[2] = in_item_i.in_z;

  apt_coef_store #(.FRAC_BITS(FRAC_BITS)) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .coef_o (coef)
  );

  apt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i && is_xf),
    .ready_o (mul_ready),
    .point_i (in_item_i.action == ActPoint),
    .vec_i   (vec),
    .coef_i  (coef),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .psum_o  (psum)
  );

  apt_sum_sat #(.FRAC_BITS(FRAC_BITS)) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mid_valid),
    .ready_o     (mid_ready),
    .psum_i      (psum),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  localparam word_t WMax = {1'b0, {(WordW-1){1'b1}}};
  localparam word_t WMin = {1'b1, {(WordW-1){1'b0}}};

  // back-pressure only ever comes from a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // a saturated result carries a rail value in some component
  a_ovf_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.overflow) |->
      (out_item_o.out_x == WMax || out_item_o.out_x == WMin ||
       out_item_o.out_y == WMax || out_item_o.out_y == WMin ||
       out_item_o.out_z == WMax || out_item_o.out_z == WMin))
    else $error("overflow flagged without a saturated component");

  // a coefficient write lands in the store
  a_coef_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && wr.idx < CoefIdxW'(CoefNum)) |=> (coef[$past(wr.idx)] == $past(wr.value)))
    else $error("coefficient write lost");

endmodule
